### rtl/rwc_pkg.sv
// rwc_pkg: shared types and constants of the replay window checker
// holds the register map, the configuration struct and the field widths
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

   // field widths
   localparam int unsigned FIELD_W     = 32;
   localparam int unsigned LIMIT_W     = 4;
   localparam int unsigned HOLDOFF_W   = 16;

   // configuration port
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_SEL_BIT = 2;

   // reset values of the registers
   localparam logic [LIMIT_W-1:0]   UNDERFLOW_LIMIT_RESET = 4'd8;
   localparam logic [HOLDOFF_W-1:0] REGEN_HOLDOFF_RESET   = 16'd3000;

   // default size of the seen bitmap
   localparam int unsigned WINDOW_BITS_DEFAULT = 64;

   typedef enum logic {
      REG_UNDERFLOW_LIMIT = 1'b0,
      REG_REGEN_HOLDOFF   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]   underflow_limit;
      logic [HOLDOFF_W-1:0] regen_holdoff_ms;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/rwc_csr.sv
// rwc_csr: configuration registers behind the apb-style port
// depends on rwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rwc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rwc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rwc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [rwc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   output rwc_pkg::cfg_type                     cfg
);
   import rwc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type sel;
   logic          wr_en;

   assign sel    = csr_index_type'(paddr[CSR_SEL_BIT]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            REG_UNDERFLOW_LIMIT: cfg_in.underflow_limit  = pwdata[LIMIT_W-1:0];
            REG_REGEN_HOLDOFF:   cfg_in.regen_holdoff_ms = pwdata[HOLDOFF_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_UNDERFLOW_LIMIT: prdata = CSR_DATA_W'(cfg_ff.underflow_limit);
         REG_REGEN_HOLDOFF:   prdata = CSR_DATA_W'(cfg_ff.regen_holdoff_ms);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.underflow_limit  <= UNDERFLOW_LIMIT_RESET;
         cfg_ff.regen_holdoff_ms <= REGEN_HOLDOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/rwc_window.sv
// rwc_window: window state and the per-frame accept / stale decision
// depends on rwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rwc_window #(
   parameter int unsigned WINDOW_BITS = rwc_pkg::WINDOW_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [rwc_pkg::FIELD_W-1:0]  frame_nonce,
   input  wire logic [rwc_pkg::FIELD_W-1:0]  frame_counter,
   input  wire logic [rwc_pkg::FIELD_W-1:0]  current_challenge,
   input  wire logic [rwc_pkg::FIELD_W-1:0]  time_ms,
   input  rwc_pkg::cfg_type                  cfg,
   output logic                              accepted,
   output logic                              request_new_challenge
);
   import rwc_pkg::*;

   localparam int unsigned SHW = $clog2(WINDOW_BITS);
   localparam logic [FIELD_W-1:0] WIN_SIZE = FIELD_W'(WINDOW_BITS);

   logic [FIELD_W-1:0]     challenge_ff, challenge_in;
   logic [FIELD_W-1:0]     top_ff, top_in;
   logic [WINDOW_BITS-1:0] bitmap_ff, bitmap_in;
   logic [LIMIT_W-1:0]     stale_ff, stale_in;
   logic [FIELD_W-1:0]     last_req_ff, last_req_in;

   // state as seen after a possible challenge change
   logic                   new_chal;
   logic [FIELD_W-1:0]     top_cur;
   logic [WINDOW_BITS-1:0] bitmap_cur;
   logic [LIMIT_W-1:0]     stale_cur;

   logic [FIELD_W-1:0]     ahead;
   logic [FIELD_W-1:0]     behind;
   logic [LIMIT_W-1:0]     stale_inc;
   logic [FIELD_W-1:0]     elapsed;
   logic                   valid_tag;

   assign new_chal   = current_challenge != challenge_ff;
   assign top_cur    = new_chal ? '0 : top_ff;
   assign bitmap_cur = new_chal ? '0 : bitmap_ff;
   assign stale_cur  = new_chal ? '0 : stale_ff;

   assign ahead     = frame_counter - top_cur;
   assign behind    = top_cur - frame_counter;
   assign stale_inc = stale_cur + LIMIT_W'(1);
   assign elapsed   = time_ms - last_req_ff;
   assign valid_tag = (frame_nonce == current_challenge) && (frame_counter != '0);

   always_comb begin
      challenge_in          = current_challenge;
      top_in                = top_cur;
      bitmap_in             = bitmap_cur;
      stale_in              = stale_cur;
      last_req_in           = last_req_ff;
      accepted              = 1'b0;
      request_new_challenge = 1'b0;
      if (valid_tag) begin
         if (frame_counter > top_cur) begin
            // newer than anything seen: slide the window up
            if (ahead >= WIN_SIZE) begin
               bitmap_in = WINDOW_BITS'(1);
            end else begin
               bitmap_in = (bitmap_cur << ahead[SHW-1:0]) | WINDOW_BITS'(1);
            end
            top_in   = frame_counter;
            stale_in = '0;
            accepted = 1'b1;
         end else if (behind < WIN_SIZE) begin
            // inside the window: accept once
            if (!bitmap_cur[behind[SHW-1:0]]) begin
               bitmap_in = bitmap_cur | (WINDOW_BITS'(1) << behind[SHW-1:0]);
               accepted  = 1'b1;
            end
         end else begin
            // too old
            stale_in = stale_inc;
            if (stale_inc >= cfg.underflow_limit) begin
               if (elapsed > FIELD_W'(cfg.regen_holdoff_ms)) begin
                  last_req_in           = time_ms;
                  request_new_challenge = 1'b1;
               end
               stale_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         challenge_ff <= '0;
         top_ff       <= '0;
         bitmap_ff    <= '0;
         stale_ff     <= '0;
         last_req_ff  <= '0;
      end else if (step) begin
         challenge_ff <= challenge_in;
         top_ff       <= top_in;
         bitmap_ff    <= bitmap_in;
         stale_ff     <= stale_in;
         last_req_ff  <= last_req_in;
      end
   end

endmodule

`default_nettype wire

### rtl/replay_window_checker.sv
// replay_window_checker: sliding-window anti-replay check, top level
// holds the input and result registers, the csr block and the window logic
// depends on rwc_pkg, rwc_csr, rwc_window
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   frame_nonce, frame_counter, current_challenge,
//                                             time_ms
//  rsp       out        rsp_valid/rsp_stall   accepted, request_new_challenge
//  csr       in/out     psel/penable/pready   paddr, pwdata, prdata (underflow_limit at 0,
//                                             regen_holdoff_ms at 4)
//
//  one item per cycle sustained while rsp_stall is low; an accepted item passes through the
//  input register and then the result register, whose valid flag drives rsp_valid
//  the window decision is combinational logic between the input and result registers
//  reset is synchronous; it empties both registers and clears the window state
//  a stalled result holds; the input side keeps taking items until both registers are full

module replay_window_checker #(
   parameter int unsigned WINDOW_BITS = rwc_pkg::WINDOW_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [rwc_pkg::FIELD_W-1:0]     req_frame_nonce,
   input  wire logic [rwc_pkg::FIELD_W-1:0]     req_frame_counter,
   input  wire logic [rwc_pkg::FIELD_W-1:0]     req_current_challenge,
   input  wire logic [rwc_pkg::FIELD_W-1:0]     req_time_ms,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_accepted,
   output logic                                 rsp_request_new_challenge,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rwc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rwc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [rwc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);
   import rwc_pkg::*;

   cfg_type cfg;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [FIELD_W-1:0] nonce_ff, counter_ff, challenge_ff, time_ff;

   // result register
   logic out_valid_ff, out_valid_in;
   logic accepted_ff, request_ff;

   logic take_req;     // item accepted on the req side
   logic advance;      // item moves from input register to result register
   logic accepted_w;
   logic request_w;

   // result register is free when empty or draining this cycle
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign take_req  = req_valid & ~req_stall;

   assign in_valid_in  = take_req | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   rwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // state only moves when the item leaves the input register
   rwc_window #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_window (
      .clock                 (clock),
      .reset                 (reset),
      .step                  (advance),
      .frame_nonce           (nonce_ff),
      .frame_counter         (counter_ff),
      .current_challenge     (challenge_ff),
      .time_ms               (time_ff),
      .cfg                   (cfg),
      .accepted              (accepted_w),
      .request_new_challenge (request_w)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take_req) begin
         nonce_ff     <= req_frame_nonce;
         counter_ff   <= req_frame_counter;
         challenge_ff <= req_current_challenge;
         time_ff      <= req_time_ms;
      end
      if (advance) begin
         accepted_ff <= accepted_w;
         request_ff  <= request_w;
      end
   end

   assign rsp_valid                 = out_valid_ff;
   assign rsp_accepted              = accepted_ff;
   assign rsp_request_new_challenge = request_ff;

endmodule

`default_nettype wire
